@@ src/sbfd_pkg.sv @@
// shared types, constants and crc function for the beacon frame decoder
`timescale 1ns / 1ps
`default_nettype none

package sbfd_pkg;

   // frame layout
   localparam int unsigned FRAME_LEN  = 36;
   localparam int unsigned CRC_SPAN   = 32;
   localparam int unsigned COUNT_W    = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
   localparam logic [COUNT_W-1:0] LAST_IDX  = 6'(FRAME_LEN - 1);

   // crc-32c, reflected
   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // beacon magic, first byte in the low lane
   localparam logic [31:0] MAGIC_WORD = 32'h4E59_534E;

   // expected size field
   localparam logic [15:0] SIZE_VALUE = 16'(FRAME_LEN);

   // register indexes
   localparam logic CSR_VERSION = 1'b0;
   localparam logic CSR_TYPE    = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_LENGTH  = 3'd1;
   localparam logic [2:0] ST_MAGIC   = 3'd2;
   localparam logic [2:0] ST_VERSION = 3'd3;
   localparam logic [2:0] ST_TYPE    = 3'd4;
   localparam logic [2:0] ST_SIZE    = 3'd5;
   localparam logic [2:0] ST_SESSION = 3'd6;
   localparam logic [2:0] ST_CRC     = 3'd7;

   // one received byte
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } in_item_type;

   // one decoded frame
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] node_id;
      logic [31:0] session_id;
      logic [31:0] sequence_number;
      logic [63:0] timestamp_us;
      logic [31:0] capabilities;
   } result_type;

   // crc-32c update by one byte
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // magic byte at a given offset
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      return MAGIC_WORD[8*idx +: 8];
   endfunction

endpackage

`default_nettype wire

@@ src/sbfd_in_reg.sv @@
// input register stage for received bytes
`timescale 1ns / 1ps
`default_nettype none

module sbfd_in_reg
   import sbfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic        advance,
   output in_item_type      item
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   // register is free when empty or when its byte moves on this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_data_byte;
         last_in  = req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign item = '{valid: valid_ff, data_byte: data_ff, last_byte: last_ff};

endmodule

`default_nettype wire

@@ src/sbfd_frame_engine.sv @@
// per-byte frame state: crc, field capture, checks and result build
`timescale 1ns / 1ps
`default_nettype none

module sbfd_frame_engine
   import sbfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  in_item_type      item,
   input  wire logic        out_busy,
   input  wire logic [7:0]  expected_version,
   input  wire logic [7:0]  expected_type,
   output logic             advance,
   output logic             res_valid,
   output result_type       res
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        crc_ff, crc_in;
   logic [2:0]         err_ff, err_in;
   logic [31:0]        node_ff, node_in;
   logic [31:0]        session_ff, session_in;
   logic [31:0]        sequence_ff, sequence_in;
   logic [63:0]        time_ff, time_in;
   logic [31:0]        caps_ff, caps_in;
   logic [31:0]        stored_crc_ff, stored_crc_in;
   logic [15:0]        size_ff, size_in;

   // the last byte waits while the output register is still held
   assign advance = item.valid && (!item.last_byte || !out_busy);

   always_comb begin
      logic [7:0]  b;
      logic [2:0]  status;
      b             = item.data_byte;
      status        = ST_OK;
      count_in      = count_ff;
      crc_in        = crc_ff;
      err_in        = err_ff;
      node_in       = node_ff;
      session_in    = session_ff;
      sequence_in   = sequence_ff;
      time_in       = time_ff;
      caps_in       = caps_ff;
      stored_crc_in = stored_crc_ff;
      size_in       = size_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (advance) begin
         // crc over the header and payload
         if (count_ff < 6'(CRC_SPAN)) begin
            crc_in = crc32c_byte(crc_ff, b);
         end

         // header checks and field capture by offset
         if (count_ff < 6'd4) begin
            if (b != magic_byte(count_ff[1:0]) && err_ff == ST_OK) err_in = ST_MAGIC;
         end else if (count_ff == 6'd4) begin
            if (b != expected_version && err_ff == ST_OK) err_in = ST_VERSION;
         end else if (count_ff == 6'd5) begin
            if (b != expected_type && err_ff == ST_OK) err_in = ST_TYPE;
         end else if (count_ff < 6'd8) begin
            size_in = {b, size_ff[15:8]};
         end else if (count_ff < 6'd12) begin
            node_in = {b, node_ff[31:8]};
         end else if (count_ff < 6'd16) begin
            session_in = {b, session_ff[31:8]};
         end else if (count_ff < 6'd20) begin
            sequence_in = {b, sequence_ff[31:8]};
         end else if (count_ff < 6'd28) begin
            time_in = {b, time_ff[63:8]};
         end else if (count_ff < 6'd32) begin
            caps_in = {b, caps_ff[31:8]};
         end else if (count_ff < 6'(FRAME_LEN)) begin
            stored_crc_in = {b, stored_crc_ff[31:8]};
         end

         // saturating byte count
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 6'd1;
         end

         // end of frame: first failing check wins
         if (item.last_byte) begin
            if (count_ff != LAST_IDX) begin
               status = ST_LENGTH;
            end else if (err_ff != ST_OK) begin
               status = err_ff;
            end else if (size_ff != SIZE_VALUE) begin
               status = ST_SIZE;
            end else if (session_ff == 32'd0) begin
               status = ST_SESSION;
            end else if (stored_crc_in != ~crc_ff) begin
               status = ST_CRC;
            end

            res_valid  = 1'b1;
            res.status = status;
            if (status == ST_OK) begin
               res.node_id         = node_ff;
               res.session_id      = session_ff;
               res.sequence_number = sequence_ff;
               res.timestamp_us    = time_ff;
               res.capabilities    = caps_ff;
            end

            // ready for the next frame
            count_in      = '0;
            crc_in        = CRC_INIT;
            err_in        = ST_OK;
            node_in       = '0;
            session_in    = '0;
            sequence_in   = '0;
            time_in       = '0;
            caps_in       = '0;
            stored_crc_in = '0;
            size_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         crc_ff        <= CRC_INIT;
         err_ff        <= ST_OK;
         node_ff       <= '0;
         session_ff    <= '0;
         sequence_ff   <= '0;
         time_ff       <= '0;
         caps_ff       <= '0;
         stored_crc_ff <= '0;
         size_ff       <= '0;
      end else begin
         count_ff      <= count_in;
         crc_ff        <= crc_in;
         err_ff        <= err_in;
         node_ff       <= node_in;
         session_ff    <= session_in;
         sequence_ff   <= sequence_in;
         time_ff       <= time_in;
         caps_ff       <= caps_in;
         stored_crc_ff <= stored_crc_in;
         size_ff       <= size_in;
      end
   end

endmodule

`default_nettype wire

@@ src/sbfd_out_reg.sv @@
// result register towards the response channel
`timescale 1ns / 1ps
`default_nettype none

module sbfd_out_reg
   import sbfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        res_valid,
   input  result_type       res,
   output logic             out_busy,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output result_type       rsp_item
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // held result blocks a new one until its transfer
   assign out_busy = valid_ff && !rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = data_ff;

endmodule

`default_nettype wire

@@ src/sync_beacon_frame_decoder_unit.sv @@
// top level of the beacon frame decoder
`timescale 1ns / 1ps
`default_nettype none

// Takes a 36-byte beacon frame one byte per transfer on req_, with req_last_byte
// on the final byte, and gives one result on rsp_ per frame: a status code for
// the first failing check (length, magic, version, type, size field, zero
// session, crc-32c) and the decoded fields, all zero unless the status is ok.
// One byte is accepted every cycle unless a last byte waits in the input
// register; each byte passes that register, then a crc-32c byte update and
// field capture, which sets that rate; the result goes to the output register.
// The next frame's bytes keep flowing while it waits to be taken, except that
// frame's last byte, which waits in the input register until the held result
// goes or leaves in the same cycle.
// csr_ writes set the expected version (index 0) and type (index 1), both 1
// after reset; write them only while no frame is in progress.

module sync_beacon_frame_decoder_unit
   import sbfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_last_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_node_id,
   output logic [31:0]       rsp_session_id,
   output logic [31:0]       rsp_sequence_number,
   output logic [63:0]       rsp_timestamp_us,
   output logic [31:0]       rsp_capabilities,
   input  wire logic         csr_write_enable,
   input  wire logic         csr_index,
   input  wire logic [7:0]   csr_write_data
);

   logic [7:0]  version_ff, version_in;
   logic [7:0]  type_ff, type_in;
   in_item_type item;
   logic        advance;
   logic        out_busy;
   logic        res_valid;
   result_type  res;
   result_type  rsp_item;

   // configuration registers
   always_comb begin
      version_in = version_ff;
      type_in    = type_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VERSION: version_in = csr_write_data;
            CSR_TYPE:    type_in    = csr_write_data;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 8'd1;
         type_ff    <= 8'd1;
      end else begin
         version_ff <= version_in;
         type_ff    <= type_in;
      end
   end

   sbfd_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .item          (item)
   );

   sbfd_frame_engine u_frame_engine (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .out_busy         (out_busy),
      .expected_version (version_ff),
      .expected_type    (type_ff),
      .advance          (advance),
      .res_valid        (res_valid),
      .res              (res)
   );

   sbfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_busy  (out_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // result fields to ports
   assign rsp_status          = rsp_item.status;
   assign rsp_node_id         = rsp_item.node_id;
   assign rsp_session_id      = rsp_item.session_id;
   assign rsp_sequence_number = rsp_item.sequence_number;
   assign rsp_timestamp_us    = rsp_item.timestamp_us;
   assign rsp_capabilities    = rsp_item.capabilities;

endmodule

`default_nettype wire
